// ===== src/spd_pkg.sv =====
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types and constants for the point sort unit: record layout, store
// sizing, controller commands and datapath status.
// ----------------------------------------------------------------------------
package spd_pkg;

  // store sizing
  localparam int MAX_RECORDS = 64;
  localparam int IDX_W       = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

  // field widths
  localparam int ID_W     = 10;
  localparam int COORD_W  = 16;
  localparam int RADIUS_W = 7;
  localparam int KEY_W    = 32;

  // stream data widths, padded to whole bytes
  localparam int IN_FIELDS_W  = ID_W + 2 * COORD_W + RADIUS_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = IN_FIELDS_W + KEY_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // one stored record with its distance key
  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic [RADIUS_W-1:0]       radius;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
    logic [ID_W-1:0]           id;
  } rec_t;

  // read address selection for the record store
  typedef enum logic [2:0] {
    RD_I,   // outer position
    RD_IN,  // outer position plus one
    RD_JN,  // inner position plus one
    RD_E,   // emit position
    RD_EN   // emit position plus one
  } rd_sel_t;

  // controller to datapath
  typedef struct packed {
    logic    cap_in;     // capture an input beat
    logic    square;     // register the two squares
    logic    wr_rec;     // store the new record, bump the count
    logic    sort_init;  // outer position to zero
    logic    ld_cur;     // take the held record, set inner position
    logic    cmp;        // compare and swap against the held record
    logic    wr_cur;     // write back the held record, next outer position
    logic    em_init;    // emit position to zero
    logic    em_ld;      // load the output register
    logic    em_next;    // next emit position
    logic    clr_cnt;    // empty the store
    rd_sel_t rd_sel;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;      // captured beat closes the batch
    logic cnt_zero;  // store empty
    logic cnt_le1;   // nothing to order
    logic j_end;     // inner position at last record
    logic i_end;     // outer position at next-to-last record
    logic e_end;     // emit position at last record
  } dp_stat_t;

endpackage

// ===== src/spd_dpath.sv =====
// ----------------------------------------------------------------------------
// spd_dpath
// Datapath of the point sort unit: input capture, key computation, record
// store, held record for the exchange passes, and the output register.
// ----------------------------------------------------------------------------
module spd_dpath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [spd_pkg::ID_W-1:0]       rec_id,
  input  logic signed [spd_pkg::COORD_W-1:0] pos_x,
  input  logic signed [spd_pkg::COORD_W-1:0] pos_y,
  input  logic [spd_pkg::RADIUS_W-1:0]   radius,
  input  logic                           is_last,
  input  spd_pkg::ctl_cmd_t              cmd,
  output spd_pkg::dp_stat_t              stat,
  output spd_pkg::rec_t                  out_rec,
  output logic                           out_last
);
  import spd_pkg::*;

  rec_t              in_rec;
  logic              in_last;
  logic signed [31:0] sq_x;
  logic signed [31:0] sq_y;
  logic [KEY_W-1:0]  key_sum;

  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  i_pos;
  logic [IDX_W-1:0]  j_pos;
  logic [IDX_W-1:0]  e_pos;
  rec_t              cur;

  rec_t              mem [MAX_RECORDS];
  rec_t              rd_data;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  rec_t              wr_data;
  logic              wr_en;
  logic              full;
  logic              swap;

  // input capture and squares
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      in_rec.id     <= rec_id;
      in_rec.x      <= pos_x;
      in_rec.y      <= pos_y;
      in_rec.radius <= radius;
      in_rec.key    <= '0;
      in_last       <= is_last;
    end
    if (cmd.square) begin
      sq_x <= 32'(in_rec.x) * 32'(in_rec.x);
      sq_y <= 32'(in_rec.y) * 32'(in_rec.y);
    end
  end

  // each square is at most 2^30, so the sum fits the key
  assign key_sum = $unsigned(sq_x) + $unsigned(sq_y);
  assign full    = (count == CNT_W'(MAX_RECORDS));
  assign swap    = (cur.key < rd_data.key);

  // read address
  always_comb begin
    unique case (cmd.rd_sel)
      RD_I:    rd_addr = i_pos;
      RD_IN:   rd_addr = i_pos + IDX_W'(1);
      RD_JN:   rd_addr = j_pos + IDX_W'(1);
      RD_E:    rd_addr = e_pos;
      RD_EN:   rd_addr = e_pos + IDX_W'(1);
      default: rd_addr = i_pos;
    endcase
  end

  // single write port, one user at a time
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = i_pos;
    wr_data = cur;
    priority if (cmd.wr_rec) begin
      wr_en       = !full;
      wr_addr     = count[IDX_W-1:0];
      wr_data     = in_rec;
      wr_data.key = key_sum;
    end else if (cmd.cmp) begin
      wr_en   = swap;
      wr_addr = j_pos;
    end else if (cmd.wr_cur) begin
      wr_en   = 1'b1;
      wr_addr = i_pos;
    end else begin
      wr_en = 1'b0;
    end
  end

  // record store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // record count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clr_cnt) begin
      count <= '0;
    end else if (cmd.wr_rec && !full) begin
      count <= count + CNT_W'(1);
    end
  end

  // sort positions and the held record
  always_ff @(posedge clk) begin
    if (cmd.sort_init) begin
      i_pos <= '0;
    end else if (cmd.wr_cur) begin
      i_pos <= i_pos + IDX_W'(1);
    end
    if (cmd.ld_cur) begin
      cur   <= rd_data;
      j_pos <= i_pos + IDX_W'(1);
    end else if (cmd.cmp) begin
      j_pos <= j_pos + IDX_W'(1);
      if (swap) begin
        cur <= rd_data;
      end
    end
  end

  // emit position and output register
  always_ff @(posedge clk) begin
    if (cmd.em_init) begin
      e_pos <= '0;
    end else if (cmd.em_next) begin
      e_pos <= e_pos + IDX_W'(1);
    end
    if (cmd.em_ld) begin
      out_rec  <= rd_data;
      out_last <= stat.e_end;
    end
  end

  // status
  assign stat.last     = in_last;
  assign stat.cnt_zero = (count == '0);
  assign stat.cnt_le1  = (count <= CNT_W'(1));
  assign stat.j_end    = ((CNT_W'(j_pos) + CNT_W'(1)) == count);
  assign stat.i_end    = ((CNT_W'(i_pos) + CNT_W'(2)) == count);
  assign stat.e_end    = ((CNT_W'(e_pos) + CNT_W'(1)) == count);

endmodule

// ===== src/spd_ctrl.sv =====
// ----------------------------------------------------------------------------
// spd_ctrl
// Controller of the point sort unit: sequences loading, the exchange passes
// over the record store, and the output beats.
// ----------------------------------------------------------------------------
module spd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  spd_pkg::dp_stat_t  stat,
  output spd_pkg::ctl_cmd_t  cmd
);
  import spd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_WR,
    S_SORT,
    S_RD_I,
    S_LD_CUR,
    S_CMP,
    S_WR_I,
    S_EM_RD,
    S_EM_LD,
    S_EM_WAIT
  } state_t;

  state_t state;
  state_t state_next;

  // commands and next state
  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_I;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.cap_in = 1'b1;
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.square = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.wr_rec = 1'b1;
        state_next = stat.last ? S_SORT : S_IDLE;
      end
      S_SORT: begin
        if (stat.cnt_le1) begin
          cmd.em_init = 1'b1;
          state_next  = S_EM_RD;
        end else begin
          cmd.sort_init = 1'b1;
          state_next    = S_RD_I;
        end
      end
      S_RD_I: begin
        cmd.rd_sel = RD_I;
        state_next = S_LD_CUR;
      end
      S_LD_CUR: begin
        cmd.ld_cur = 1'b1;
        cmd.rd_sel = RD_IN;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        cmd.rd_sel = RD_JN;
        state_next = stat.j_end ? S_WR_I : S_CMP;
      end
      S_WR_I: begin
        cmd.rd_sel = RD_IN;
        if (stat.i_end) begin
          cmd.wr_cur  = 1'b1;
          cmd.em_init = 1'b1;
          state_next  = S_EM_RD;
        end else begin
          cmd.wr_cur = 1'b1;
          state_next = S_LD_CUR;
        end
      end
      S_EM_RD: begin
        cmd.rd_sel = RD_E;
        if (stat.cnt_zero) begin
          cmd.clr_cnt = 1'b1;
          state_next  = S_IDLE;
        end else begin
          state_next = S_EM_LD;
        end
      end
      S_EM_LD: begin
        cmd.em_ld  = 1'b1;
        state_next = S_EM_WAIT;
      end
      S_EM_WAIT: begin
        cmd.rd_sel = RD_EN;
        if (out_ready) begin
          if (stat.e_end) begin
            cmd.clr_cnt = 1'b1;
            state_next  = S_IDLE;
          end else begin
            cmd.em_next = 1'b1;
            state_next  = S_EM_LD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_ready  <= (state_next == S_IDLE);
      out_valid <= (state_next == S_EM_WAIT);
    end
  end

endmodule

// ===== src/sort_points_by_distance_desc_unit.sv =====
// ----------------------------------------------------------------------------
// sort_points_by_distance_desc_unit
// Collects a batch of point records, orders them by squared distance from
// the origin, largest first, with an exchange sort, and streams them out.
//
//   channel   dir  tdata fields (low bit up)                 tlast
//   s_axis    in   rec_id, pos_x, pos_y, radius              is_last
//   m_axis    out  out_id, out_x, out_y, out_radius, dist_sq out_last
//
// Loading steps through capture, squares and store write for each record.
// Ordering does one compare per cycle through the single-read-port record
// store, plus a load and a write-back for each outer position. Each output
// beat is loaded into the output register before it is offered, and the
// next beat is loaded only after the current one is taken.
// Reset empties the store; one batch at a time, no input while sorting or
// emitting. Output stalls simply hold the current beat.
// ----------------------------------------------------------------------------
module sort_points_by_distance_desc_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // rec_id[9:0], pos_x[25:10], pos_y[41:26], radius[48:42], zero fill
  input  logic [spd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_id[9:0], out_x[25:10], out_y[41:26], out_radius[48:42],
  // dist_sq[80:49], zero fill
  output logic [spd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                             m_axis_tlast
);
  import spd_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;
  rec_t     out_rec;

  spd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  spd_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .rec_id   (s_axis_tdata[ID_W-1:0]),
    .pos_x    (s_axis_tdata[ID_W +: COORD_W]),
    .pos_y    (s_axis_tdata[ID_W + COORD_W +: COORD_W]),
    .radius   (s_axis_tdata[ID_W + 2 * COORD_W +: RADIUS_W]),
    .is_last  (s_axis_tlast),
    .cmd      (cmd),
    .stat     (stat),
    .out_rec  (out_rec),
    .out_last (m_axis_tlast)
  );

  // output beat packing
  assign m_axis_tdata = {(OUT_DATA_W - OUT_FIELDS_W)'(0), out_rec.key, out_rec.radius,
                         out_rec.y, out_rec.x, out_rec.id};

endmodule

// ===== src/spd_checker.sv =====
// ----------------------------------------------------------------------------
// spd_checker
// Port-level checks for the point sort unit: output run ordering, handshake
// exclusion between load and emit, run termination, batch-close gap, stall hold.
// ----------------------------------------------------------------------------
module spd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            s_axis_tlast,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [spd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic                            m_axis_tlast
);
  import spd_pkg::*;

  logic             out_beat;
  logic             in_run;
  logic [KEY_W-1:0] prev_key;
  logic [KEY_W-1:0] cur_key;

  assign out_beat = m_axis_tvalid && m_axis_tready;
  assign cur_key  = m_axis_tdata[IN_FIELDS_W +: KEY_W];

  // track the key of the previous beat in the current run
  always_ff @(posedge clk) begin
    if (rst) begin
      in_run <= 1'b0;
    end else if (out_beat) begin
      in_run <= !m_axis_tlast;
    end
    if (out_beat) begin
      prev_key <= cur_key;
    end
  end

  // keys never rise within a run
  a_desc_order: assert property (@(posedge clk) disable iff (rst)
    out_beat && in_run |-> cur_key <= prev_key)
    else $error("output run not in descending key order");

  // no input taken while a result is on offer
  a_no_load_in_emit: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |-> !m_axis_tvalid)
    else $error("input accepted during output");

  // the run ends after its last beat
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    out_beat && m_axis_tlast |=> !m_axis_tvalid)
    else $error("output valid after last beat");

  // a batch close is not followed by output in the very next cycle
  a_close_latency: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !m_axis_tvalid)
    else $error("output too soon after batch close");

  // stalled beat holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled output beat changed");

endmodule

bind sort_points_by_distance_desc_unit spd_checker u_spd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== sim/sort_points_by_distance_desc_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sort_points_by_distance_desc_unit_tb
// Streams batches of point records into the sort unit and checks every
// output beat against an in-bench exchange sort on the squared distance.
// Covers coordinate extremes, equal distances, pass-through of odd ids and
// radii, single-record batches and batches that overflow the store.
// ----------------------------------------------------------------------------
module sort_points_by_distance_desc_unit_tb;
  import spd_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int DRAIN_CYCLES    = 300;
  localparam int RANDOM_POINTS   = 460;

  // one record with its batch-close flag (key unused on the input side)
  typedef struct packed {
    logic last;
    rec_t rec;
  } point_beat_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  point_beat_t point_queue[$];    // records waiting to be sent
  point_beat_t sorted_points[$];  // expected output beats, oldest first
  rec_t        held_points[MAX_RECORDS];
  int          held_count = 0;
  int          beats_in = 0;
  int          mismatches = 0;
  int          idle_cycles = 0;
  logic        calm;

  // stretch with no idling on either side
  assign calm = (beats_in >= 200) && (beats_in < 300);

  sort_points_by_distance_desc_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // exact x*x + y*y
  function automatic logic [KEY_W-1:0] dist_sq_of(logic [COORD_W-1:0] x,
                                                  logic [COORD_W-1:0] y);
    longint sx, sy;
    sx = $signed(x);
    sy = $signed(y);
    return KEY_W'(sx * sx + sy * sy);
  endfunction

  // store an accepted record; on batch close, sort descending and queue results
  function automatic void take_point(point_beat_t b);
    rec_t r, t;
    if (held_count < MAX_RECORDS) begin
      r = b.rec;
      r.key = dist_sq_of(r.x, r.y);
      held_points[held_count] = r;
      held_count++;
    end
    if (!b.last) return;
    for (int i = 0; i + 1 < held_count; i++) begin
      for (int j = i + 1; j < held_count; j++) begin
        if (held_points[i].key < held_points[j].key) begin
          t = held_points[i];
          held_points[i] = held_points[j];
          held_points[j] = t;
        end
      end
    end
    for (int i = 0; i < held_count; i++) begin
      sorted_points.push_back('{last: (i + 1 == held_count), rec: held_points[i]});
    end
    held_count = 0;
  endfunction

  function automatic void add_point(int id, int x, int y, int radius, bit last);
    point_beat_t b;
    b.rec.id     = ID_W'(id);
    b.rec.x      = COORD_W'(x);
    b.rec.y      = COORD_W'(y);
    b.rec.radius = RADIUS_W'(radius);
    b.rec.key    = '0;
    b.last       = last;
    point_queue.push_back(b);
  endfunction

  // coordinate: full range, small (many equal distances) or an extreme
  function automatic int rand_coord();
    int mode;
    mode = $urandom_range(9);
    if (mode < 5) return int'($signed(16'($urandom)));
    if (mode < 8) return $urandom_range(16) - 8;
    case ($urandom_range(3))
      0: return -32768;
      1: return 32767;
      2: return -32767;
      default: return 0;
    endcase
  endfunction

  // input driver
  always @(posedge clk) begin : point_driver
    point_beat_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        take_point('{last: s_axis_tlast,
                     rec: '{key: '0,
                            radius: s_axis_tdata[48:42],
                            y: s_axis_tdata[41:26],
                            x: s_axis_tdata[25:10],
                            id: s_axis_tdata[9:0]}});
        beats_in <= beats_in + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (point_queue.size() != 0 && (calm || $urandom_range(99) >= 18)) begin
          nxt = point_queue.pop_front();
          s_axis_tdata  <= {7'b0, nxt.rec.radius, nxt.rec.y, nxt.rec.x, nxt.rec.id};
          s_axis_tlast  <= nxt.last;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor and back-pressure
  always @(posedge clk) begin : sorted_monitor
    point_beat_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (sorted_points.size() == 0) begin
          $error("unexpected output beat: out_id %0d", m_axis_tdata[9:0]);
          mismatches++;
        end else begin
          want = sorted_points.pop_front();
          if (m_axis_tdata[9:0] !== want.rec.id) begin
            $error("out_id: expected %0d, actual %0d", want.rec.id, m_axis_tdata[9:0]);
            mismatches++;
          end
          if (m_axis_tdata[25:10] !== want.rec.x) begin
            $error("out_x: expected %0d, actual %0d",
                   $signed(want.rec.x), $signed(m_axis_tdata[25:10]));
            mismatches++;
          end
          if (m_axis_tdata[41:26] !== want.rec.y) begin
            $error("out_y: expected %0d, actual %0d",
                   $signed(want.rec.y), $signed(m_axis_tdata[41:26]));
            mismatches++;
          end
          if (m_axis_tdata[48:42] !== want.rec.radius) begin
            $error("out_radius: expected %0d, actual %0d",
                   want.rec.radius, m_axis_tdata[48:42]);
            mismatches++;
          end
          if (m_axis_tdata[80:49] !== want.rec.key) begin
            $error("dist_sq: expected %0d, actual %0d", want.rec.key, m_axis_tdata[80:49]);
            mismatches++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("out_last: expected %0d, actual %0d", want.last, m_axis_tlast);
            mismatches++;
          end
        end
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 18);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (!rst) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int sent, batch, size;

    // single record at the largest distance
    add_point(0, -32768, -32768, 1, 1'b1);
    // extremes, odd ids and radii, equal keys at 2^30
    add_point(1023, 32767, 32767, 127, 1'b0);
    add_point(999, 0, 0, 0, 1'b0);
    add_point(512, -32768, 0, 100, 1'b0);
    add_point(341, 0, -32768, 64, 1'b1);
    // equal distance 25 in several forms, mixed with others
    add_point(10, 3, 4, 5, 1'b0);
    add_point(11, 1, 1, 5, 1'b0);
    add_point(12, -4, 3, 5, 1'b0);
    add_point(13, 5, 0, 5, 1'b0);
    add_point(14, 0, -5, 5, 1'b0);
    add_point(15, 7, -1, 5, 1'b0);
    add_point(16, -3, -4, 5, 1'b0);
    add_point(17, 4, -3, 5, 1'b1);
    // ascending input
    add_point(20, 1, 0, 9, 1'b0);
    add_point(21, 2, 0, 9, 1'b0);
    add_point(22, 3, 0, 9, 1'b0);
    add_point(23, 4, 0, 9, 1'b0);
    add_point(24, 5, 0, 9, 1'b1);
    // descending input
    add_point(30, -300, 200, 33, 1'b0);
    add_point(31, -200, 100, 33, 1'b0);
    add_point(32, 100, -50, 33, 1'b0);
    add_point(33, 1, -1, 33, 1'b1);

    // random batches; a few fill or overflow the store
    sent = 0;
    batch = 0;
    while (sent < RANDOM_POINTS) begin
      if (batch == 4) size = MAX_RECORDS + 2;
      else if (batch == 11) size = MAX_RECORDS;
      else if ($urandom_range(29) == 0) size = $urandom_range(MAX_RECORDS + 6, 56);
      else size = $urandom_range(10, 1);
      for (int k = 0; k < size; k++) begin
        add_point(($urandom_range(7) == 0) ? $urandom_range(1023) : $urandom_range(999),
                  rand_coord(), rand_coord(),
                  ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(100, 1),
                  k == size - 1);
      end
      sent += size;
      batch++;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (point_queue.size() != 0 || s_axis_tvalid || sorted_points.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sort_points_by_distance_desc_unit.f =====
src/spd_pkg.sv
src/spd_dpath.sv
src/spd_ctrl.sv
src/sort_points_by_distance_desc_unit.sv
src/spd_checker.sv
sim/sort_points_by_distance_desc_unit_tb.sv
